@@ hw/rtl/brle_pkg.sv @@
// Shared types and constants for the bit run-length encoder.
package brle_pkg;

    // Field widths
    localparam int unsigned DATA_W = 8;
    localparam int unsigned LEN_W  = 7;

    // Configuration reset value of the longest run per code
    localparam logic [LEN_W-1:0] MAX_RUN_RST = 7'd127;

    // Queue depths
    localparam int unsigned IQ_DEPTH = 2;
    localparam int unsigned OQ_DEPTH = 4;

    // One input byte with its end-of-stream flag
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              final_byte;
    } t_item;

    // One result code with its framing flags
    typedef struct packed {
        logic [DATA_W-1:0] run_code;
        logic              last_of_item;
        logic              end_of_stream;
    } t_code;

endpackage

@@ hw/rtl/brle_front.sv @@
// Input side: accepts bytes into a two-entry queue ahead of the bit engine.
module brle_front
    import brle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int unsigned AW = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
    localparam int unsigned CW = $clog2(IQ_DEPTH + 1);

    t_item         r_mem [IQ_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(IQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(IQ_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(IQ_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming byte
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hw/rtl/brle_back.sv @@
// Bit engine: turns bytes MSB first into run codes, one bit per unstalled cycle.
module brle_back
    import brle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             i_item_valid,
    input  t_item            i_item,
    output logic             o_item_pop,
    output logic             o_code_push,
    output t_code            o_code,
    input  logic             i_code_full
);

    localparam int unsigned IW = $clog2(DATA_W);

    logic [LEN_W-1:0]  r_max;
    logic              r_busy, n_busy;
    logic              r_flush, n_flush;
    logic [IW-1:0]     r_idx, n_idx;
    logic [DATA_W-1:0] r_data;
    logic              r_final;
    logic              r_bit, n_bit;
    logic [LEN_W-1:0]  r_count, n_count;
    t_code             r_hold, n_hold;
    logic              r_hold_v, n_hold_v;
    logic              r_hold_closed, n_hold_closed;

    logic [LEN_W-1:0]  limit;
    logic [LEN_W-1:0]  cnt1;
    logic              cur_b;
    logic              differ;
    logic              c_v;
    logic              c_bit;
    logic [LEN_W-1:0]  c_len;
    logic              s_bit;
    logic [LEN_W-1:0]  s_count;
    logic              s_adv;
    logic              s_last_bit;
    logic              s_end;
    logic              can_push;
    logic              stall;
    logic              step_ok;
    logic              taken;
    logic              done;
    logic              push;
    logic              pop_item;

    // Hold the run limit; zero acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RUN_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // Classify the current bit and form at most one code
    always_comb begin
        limit   = (r_max == '0) ? LEN_W'(1) : r_max;
        cur_b   = r_data[r_idx];
        differ  = (r_count != '0) && (cur_b != r_bit);
        cnt1    = r_count + LEN_W'(1);
        c_v     = 1'b0;
        c_bit   = r_bit;
        c_len   = r_count;
        s_bit   = r_bit;
        s_count = r_count;
        s_adv   = 1'b0;
        if (r_flush) begin
            c_v     = (r_count != '0);
            s_bit   = 1'b0;
            s_count = '0;
        end else if (differ) begin
            c_v = 1'b1;
            if (limit == LEN_W'(1)) begin
                // new bit is not consumed; it is retried as a fresh run
                s_count = '0;
            end else begin
                s_bit   = cur_b;
                s_count = LEN_W'(1);
                s_adv   = 1'b1;
            end
        end else begin
            s_bit = cur_b;
            s_adv = 1'b1;
            if (cnt1 >= limit) begin
                c_v     = 1'b1;
                c_bit   = cur_b;
                c_len   = cnt1;
                s_count = '0;
            end else begin
                s_count = cnt1;
            end
        end
        s_last_bit = s_adv && (r_idx == '0);
        s_end      = r_flush || (s_last_bit && !r_final);
        can_push   = !i_code_full;
        stall      = c_v && r_hold_v && !can_push;
        step_ok    = r_busy && !stall;
        taken      = step_ok && c_v;
        done       = step_ok && s_end;
        push       = r_hold_v && can_push && (r_hold_closed || taken);
        pop_item   = i_item_valid && (!r_busy || done);
    end

    // Advance the run state, bit index and item load
    always_comb begin
        n_busy  = r_busy;
        n_flush = r_flush;
        n_idx   = r_idx;
        n_bit   = r_bit;
        n_count = r_count;
        if (step_ok) begin
            n_bit   = s_bit;
            n_count = s_count;
            if (s_adv) begin
                n_idx = r_idx - IW'(1);
            end
            if (s_last_bit && r_final) begin
                n_flush = 1'b1;
            end
        end
        if (pop_item) begin
            n_busy  = 1'b1;
            n_flush = 1'b0;
            n_idx   = IW'(DATA_W - 1);
        end else if (done) begin
            n_busy  = 1'b0;
            n_flush = 1'b0;
        end
    end

    // Keep the newest code until it is known whether it ends its byte
    always_comb begin
        n_hold        = r_hold;
        n_hold_v      = r_hold_v;
        n_hold_closed = r_hold_closed;
        if (taken) begin
            n_hold.run_code      = {c_bit, c_len};
            n_hold.last_of_item  = s_end;
            n_hold.end_of_stream = s_end && r_final;
            n_hold_v             = 1'b1;
            n_hold_closed        = s_end;
        end else if (push) begin
            n_hold_v      = 1'b0;
            n_hold_closed = 1'b0;
        end else if (done && r_hold_v && !r_hold_closed) begin
            n_hold.last_of_item  = 1'b1;
            n_hold.end_of_stream = r_final;
            n_hold_closed        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_flush       <= 1'b0;
            r_idx         <= '0;
            r_bit         <= 1'b0;
            r_count       <= '0;
            r_hold_v      <= 1'b0;
            r_hold_closed <= 1'b0;
        end else begin
            r_busy        <= n_busy;
            r_flush       <= n_flush;
            r_idx         <= n_idx;
            r_bit         <= n_bit;
            r_count       <= n_count;
            r_hold_v      <= n_hold_v;
            r_hold_closed <= n_hold_closed;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (pop_item) begin
            r_data  <= i_item.data_byte;
            r_final <= i_item.final_byte;
        end
    end

    assign o_item_pop  = pop_item;
    assign o_code_push = push;
    assign o_code      = r_hold;

    // A closed code is always a held code
    a_closed_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_closed |-> r_hold_v)
        else $error("closed hold without a held code");

    // Flush phase only inside a loaded byte
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_busy && (r_idx == IW'(DATA_W - 1))))
        else $error("flush phase outside a byte");

    // End of stream marks only the last code of a byte
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_v && r_hold.end_of_stream) |-> r_hold.last_of_item)
        else $error("end of stream without last of item");

    // After a stream ends the run state is clear
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && step_ok) |=> (r_count == '0) && !r_bit)
        else $error("run state not cleared after flush");

endmodule

@@ hw/rtl/brle_out.sv @@
// Result side: four-entry queue of run codes toward the consumer.
module brle_out
    import brle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_code i_code,
    output logic  o_full,
    output logic  o_empty,
    output t_code o_code,
    input  logic  i_pop
);

    localparam int unsigned AW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int unsigned CW = $clog2(OQ_DEPTH + 1);

    t_code         r_mem [OQ_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(OQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_code  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(OQ_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(OQ_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming code
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_code;
        end
    end

endmodule

@@ hw/rtl/bit_run_length_encoder.sv @@
// Top level of the bit run-length encoder.
// Bytes enter a two-deep queue and are encoded MSB first by a bit engine that
// handles one bit per clock unless stalled; a byte flagged final gets an extra
// step that flushes the pending run. When max_run is 1 and a run left pending
// under a larger limit meets a different bit, that bit is retried as a fresh
// run. Each code is held in the engine until the next code or the end of its
// byte shows whether it closes that byte, then moves into a four-deep result
// queue; the engine stalls only while that queue is full. Write max_run only
// while the block is idle; 0 acts as 1.
module bit_run_length_encoder
    import brle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_final_byte,
    output logic              empty,
    input  logic              pop,
    output logic [DATA_W-1:0] o_run_code,
    output logic              o_last_of_item,
    output logic              o_end_of_stream
);

    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  q_pop;
    t_code eng_code;
    logic  eng_push;
    logic  out_full;
    t_code out_code;

    assign in_item.data_byte  = i_data_byte;
    assign in_item.final_byte = i_final_byte;

    // Accept bytes
    brle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Encode bits into run codes
    brle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_code_push  (eng_push),
        .o_code       (eng_code),
        .i_code_full  (out_full)
    );

    // Queue results for transfer
    brle_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (eng_push),
        .i_code  (eng_code),
        .o_full  (out_full),
        .o_empty (empty),
        .o_code  (out_code),
        .i_pop   (pop)
    );

    assign o_run_code      = out_code.run_code;
    assign o_last_of_item  = out_code.last_of_item;
    assign o_end_of_stream = out_code.end_of_stream;

endmodule
